@@ rtl/rcfe_pkg.sv @@
// Package for the RC channel frame encoder.
// Holds frame constants, the sequencer state type and the CRC-8 byte update.
// No dependencies.
package rcfe_pkg;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned CH_IDX_W     = $clog2(NUM_CHANNELS);

  localparam logic [10:0] CH_MIN  = 11'd172;
  localparam logic [10:0] CH_MAX  = 11'd1811;
  localparam logic [10:0] CH_SPAN = 11'd1639;

  localparam logic [7:0] FRAME_SYNC   = 8'hC8;
  localparam logic [7:0] FRAME_LENGTH = 8'd24;
  localparam logic [7:0] FRAME_TYPE   = 8'h16;
  localparam logic [7:0] CRC_POLY     = 8'hD5;

  // Byte positions inside the 26-byte frame.
  localparam logic [4:0] IDX_SYNC      = 5'd0;
  localparam logic [4:0] IDX_LENGTH    = 5'd1;
  localparam logic [4:0] IDX_TYPE      = 5'd2;
  localparam logic [4:0] IDX_LAST_PACK = 5'd24;
  localparam logic [4:0] IDX_CRC       = 5'd25;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EMIT
  } rcfe_state_e;

  // One byte through the CRC-8 register, MSB first, init handled by the caller.
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int j = 0; j < 8; j++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/rcfe_scaler.sv @@
// Two-stage stick-to-channel scaler of the RC channel frame encoder.
// Multiplies by the channel span, then divides by 2^k-1 with one correction.
// Depends on rcfe_pkg.
module rcfe_scaler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] value_i,
  input  logic        throttle_i,
  output logic        done_o,
  output logic [10:0] result_o
);
  import rcfe_pkg::*;

  logic [26:0] prod_q, prod_d;
  logic        thr_q;
  logic        busy_q;
  logic        done_q;
  logic [10:0] result_q, result_d;

  logic [11:0] quot_raw;
  logic [16:0] rem_part;
  logic [16:0] rem_sum;
  logic [16:0] divisor;
  logic [11:0] quot;
  logic [11:0] chan_sum;

  assign prod_d = {11'd0, value_i} * {16'd0, CH_SPAN};

  // Division by 2^k-1: p = q*(2^k-1) + (q + p mod 2^k); the remainder stays
  // below twice the divisor, so one compare and increment finishes it.
  always_comb begin
    if (thr_q) begin
      quot_raw = prod_q[26:15];
      rem_part = {2'd0, prod_q[14:0]};
      divisor  = 17'd32767;
    end else begin
      quot_raw = {1'b0, prod_q[26:16]};
      rem_part = {1'b0, prod_q[15:0]};
      divisor  = 17'd65535;
    end
    rem_sum  = rem_part + {5'd0, quot_raw};
    quot     = (rem_sum >= divisor) ? quot_raw + 12'd1 : quot_raw;
    chan_sum = quot + {1'b0, CH_MIN};
    result_d = (chan_sum > {1'b0, CH_MAX}) ? CH_MAX : chan_sum[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
      thr_q  <= throttle_i;
    end
    if (busy_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/rc_channel_frame_encoder_top.sv @@
// Scaling steps: the product is registered on acceptance, then the divided and clamped
// result, then it goes to the channel store; only then is the next word taken. After the
// sixteenth the 26-byte frame leaves at one word per cycle while the output side is ready,
// no input is taken then, and its first byte is registered once the emit state is entered.
// Reset (rst_ni low, asynchronous) clears the mask, channel counter and all handshake state;
// the channel store is not cleared, since a frame is only built after all channels are written.
// Top level of the RC channel frame encoder. Depends on rcfe_pkg and rcfe_scaler.
module rc_channel_frame_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: throttle_mask, one bit per channel.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Input words: stick_value [15:0], signed.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // Output words: frame_byte [7:0]; tlast carries last_byte.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import rcfe_pkg::*;

  rcfe_state_e state_q, state_d;

  logic [15:0]         mask_q;
  logic [CH_IDX_W-1:0] chan_q;
  logic [10:0]         store_q [NUM_CHANNELS];

  // Frame build state: byte position, packing accumulator and its fill, CRC.
  logic [4:0]          byte_idx_q;
  logic [18:0]         acc_q;
  logic [4:0]          nbits_q;
  logic [CH_IDX_W-1:0] rd_ch_q;
  logic [7:0]          crc_q;

  logic                out_valid_q;
  logic [7:0]          out_data_q;
  logic                out_last_q;

  logic                in_accept;
  logic                scale_start;
  logic                scale_done;
  logic [10:0]         scale_result;
  logic [15:0]         scale_operand;
  logic                chan_thr;
  logic                out_load;
  logic                emitting;

  logic                need_load;
  logic [18:0]         acc_ext;
  logic [4:0]          nbits_ext;
  logic [7:0]          next_byte;
  logic                feeds_crc;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign chan_thr  = mask_q[chan_q];

  // Throttle mode clamps negatives to zero; bipolar mode offsets by half range.
  always_comb begin
    if (chan_thr) begin
      scale_operand = s_axis_tdata_i[15] ? 16'd0 : {1'b0, s_axis_tdata_i[14:0]};
    end else begin
      scale_operand = {~s_axis_tdata_i[15], s_axis_tdata_i[14:0]};
    end
  end

  rcfe_scaler u_scaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scale_start),
    .value_i    (scale_operand),
    .throttle_i (chan_thr),
    .done_o     (scale_done),
    .result_o   (scale_result)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_d = (chan_q == CH_IDX_W'(NUM_CHANNELS - 1)) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_load && byte_idx_q == IDX_CRC) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    emitting        = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_SCALE: s_axis_tready_o = 1'b0;
      ST_EMIT:  emitting        = 1'b1;
      default:  s_axis_tready_o = 1'b0;
    endcase
  end

  assign scale_start = in_accept;
  assign out_load    = emitting && (!out_valid_q || m_axis_tready_i);

  // Packing: when fewer than eight bits wait, the next channel joins above them.
  assign need_load = (nbits_q < 5'd8);
  assign acc_ext   = need_load ? (acc_q | ({8'd0, store_q[rd_ch_q]} << nbits_q)) : acc_q;
  assign nbits_ext = need_load ? nbits_q + 5'd11 : nbits_q;
  assign feeds_crc = (byte_idx_q >= IDX_TYPE) && (byte_idx_q <= IDX_LAST_PACK);

  always_comb begin
    case (byte_idx_q)
      IDX_SYNC:   next_byte = FRAME_SYNC;
      IDX_LENGTH: next_byte = FRAME_LENGTH;
      IDX_TYPE:   next_byte = FRAME_TYPE;
      IDX_CRC:    next_byte = crc_q;
      default:    next_byte = acc_ext[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= 16'd0;
      chan_q      <= '0;
      byte_idx_q  <= 5'd0;
      acc_q       <= 19'd0;
      nbits_q     <= 5'd0;
      rd_ch_q     <= '0;
      crc_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (state_q == ST_SCALE && scale_done) begin
        chan_q     <= chan_q + 1'b1;
        byte_idx_q <= 5'd0;
        acc_q      <= 19'd0;
        nbits_q    <= 5'd0;
        rd_ch_q    <= '0;
        crc_q      <= 8'd0;
      end
      if (out_load) begin
        byte_idx_q <= byte_idx_q + 5'd1;
        if (feeds_crc) begin
          crc_q <= crc_next(crc_q, next_byte);
        end
        if (byte_idx_q > IDX_TYPE && byte_idx_q <= IDX_LAST_PACK) begin
          acc_q   <= acc_ext >> 8;
          nbits_q <= nbits_ext - 5'd8;
          if (need_load) begin
            rd_ch_q <= rd_ch_q + 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCALE && scale_done) begin
      store_q[chan_q] <= scale_result;
    end
    if (out_load) begin
      out_data_q <= next_byte;
      out_last_q <= (byte_idx_q == IDX_CRC);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  a_done_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> state_q == ST_SCALE)
    else $error("scaler finished outside the scale state");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> (scale_result >= CH_MIN && scale_result <= CH_MAX))
    else $error("scaled channel value out of range");

  a_last_chan_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE && scale_done && chan_q == CH_IDX_W'(NUM_CHANNELS - 1))
    |=> state_q == ST_EMIT)
    else $error("frame not started after the last channel");

  a_pack_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && byte_idx_q == IDX_CRC) |-> (nbits_q == 5'd0 && rd_ch_q == '0))
    else $error("channel bits left over at the CRC byte");

  a_no_input_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting |-> !s_axis_tready_o)
    else $error("input ready while a frame is emitted");
`endif

endmodule
